// ----- design/ipv4_fragment_header_gen_defines.svh -----
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Shared assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GEN_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GEN_DEFINES_SVH

`ifndef SYNTHESIS
`define IFHG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("IPv4 fragment header generator assertion failed");
`define IFHG_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("IPv4 fragment header generator forbidden condition");
`else
`define IFHG_ASSERT(lbl, clk, rstn, prop)
`define IFHG_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ----- design/ipv4fhg_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Sequencer states, header constants and field widths.
// ----------------------------------------------------------------------------
package ipv4fhg_pkg;

    localparam int unsigned LenW    = 16;
    localparam int unsigned AddrW   = 32;
    localparam int unsigned ProtoW  = 8;
    localparam int unsigned TlenW   = 11;
    localparam int unsigned OffW    = 13;
    localparam int unsigned WordW   = 16;
    localparam int unsigned UnitsW  = 8;
    localparam int unsigned SizeW   = UnitsW + 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned StepW   = 3;

    localparam logic [WordW-1:0]   VerIhlTos = 16'h4500;
    localparam logic [TlenW-1:0]   HdrBytes  = 11'd20;
    localparam logic [UnitsW-1:0]  MinUnits  = 8'd128;
    localparam logic [UnitsW-1:0]  MaxUnits  = 8'd185;
    localparam logic [UnitsW-1:0]  RstUnits  = 8'd185;
    localparam logic [7:0]         RstTtl    = 8'd64;
    localparam logic [StepW-1:0]   LastBaseStep = 3'd6;

    localparam logic [CfgIdxW-1:0] RegLocalIp   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegTtlValue  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegFragUnits = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_FRAG,
        S_TLEN,
        S_FO,
        S_EMIT
    } t_state;

    // Clamp the fragment size register to the supported range.
    function automatic logic [UnitsW-1:0] clamp_units(input logic [UnitsW-1:0] u);
        logic [UnitsW-1:0] r;
        r = u;
        if (u < MinUnits) r = MinUnits;
        if (u > MaxUnits) r = MaxUnits;
        return r;
    endfunction

endpackage

// ----- design/ipv4_fragment_header_gen.sv -----
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Splits a datagram descriptor into fragments and builds each IPv4 header.
// ----------------------------------------------------------------------------
// Usage: one descriptor request on the s_axis channel gives one m_axis
// request per fragment, in order, the final one with tlast set. Fragments
// are frag_units*8 bytes (frag_units clamped to 128..185); the last one
// carries the remainder, so a descriptor yields 1 to 64 fragment headers.
// The configuration channel (i_cfg_*) is always ready and writes local_ip,
// ttl_value or frag_units; the user must make writes only while the block is
// idle; the block itself does not enforce this. Sequence: after acceptance,
// the seven fixed header words are folded into a base checksum on the single
// ones-complement adder. Each fragment then passes four steps (size compare,
// add total length, add flags/offset, load the output register). s_axis_tready
// is high only while no descriptor is in work.
// The output register lets the sequencer work on the next fragment while a
// finished header waits; a receiver stall holds the sequencer at the load
// step until the register frees. Reset clears the sequencer, the output
// valid, the identification counter and sets the registers to defaults.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_gen_defines.svh"

module ipv4_fragment_header_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Descriptor input: tdata = payload_len[15:0], dst_ip[47:16], proto_num[55:48]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // Header output: tdata = total_len[10:0], ident[26:11], more_frags[27],
    // frag_offset[40:28], hdr_checksum[56:41], zero[63:57]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned WordW  = ipv4fhg_pkg::WordW;
    localparam int unsigned OutW   = 57;

    // Configuration registers
    logic [ipv4fhg_pkg::AddrW-1:0]  r_local_ip;
    logic [7:0]                     r_ttl;
    logic [ipv4fhg_pkg::UnitsW-1:0] r_frag_units;

    // Descriptor context
    ipv4fhg_pkg::t_state            r_state, n_state;
    logic [ipv4fhg_pkg::LenW-1:0]   r_rem;
    logic [ipv4fhg_pkg::AddrW-1:0]  r_dst;
    logic [ipv4fhg_pkg::ProtoW-1:0] r_proto;
    logic [WordW-1:0]               r_id;
    logic [WordW-1:0]               r_ident_cnt;
    logic [ipv4fhg_pkg::UnitsW-1:0] r_units;
    logic [ipv4fhg_pkg::OffW-1:0]   r_offs;
    logic [ipv4fhg_pkg::StepW-1:0]  r_step;
    logic [ipv4fhg_pkg::TlenW-1:0]  r_chunk;
    logic                           r_fin;
    logic [WordW-1:0]               r_base;
    logic [WordW-1:0]               r_acc;

    // Output register
    logic                           r_out_valid;
    logic [OutW-1:0]                r_out_data;
    logic                           r_out_last;

    logic                           in_fire;
    logic                           out_load;
    logic [ipv4fhg_pkg::SizeW-1:0]  frag_size;
    logic [ipv4fhg_pkg::TlenW-1:0]  tlen;
    logic [WordW-1:0]               flags_off;
    logic [WordW-1:0]               add_a, add_b, add_sum;
    logic [WordW:0]                 add_raw;

    assign o_cfg_ready   = 1'b1;
    assign frag_size     = {r_units, 3'b000};
    assign tlen          = ipv4fhg_pkg::HdrBytes + r_chunk;
    assign flags_off     = {2'b00, ~r_fin, r_offs};

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ipv4fhg_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = ipv4fhg_pkg::S_BASE;
            end
            ipv4fhg_pkg::S_BASE: begin
                if (r_step == ipv4fhg_pkg::LastBaseStep) n_state = ipv4fhg_pkg::S_FRAG;
            end
            ipv4fhg_pkg::S_FRAG: n_state = ipv4fhg_pkg::S_TLEN;
            ipv4fhg_pkg::S_TLEN: n_state = ipv4fhg_pkg::S_FO;
            ipv4fhg_pkg::S_FO:   n_state = ipv4fhg_pkg::S_EMIT;
            ipv4fhg_pkg::S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = r_fin ? ipv4fhg_pkg::S_IDLE : ipv4fhg_pkg::S_FRAG;
                end
            end
            default: n_state = ipv4fhg_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ipv4fhg_pkg::S_IDLE);
        in_fire       = s_axis_tvalid && s_axis_tready;
        out_load      = (r_state == ipv4fhg_pkg::S_EMIT) && (!r_out_valid || m_axis_tready);
        m_axis_tvalid = r_out_valid;
        m_axis_tlast  = r_out_last;
        m_axis_tdata  = {{(64 - OutW){1'b0}}, r_out_data};
    end

    // Shared ones-complement adder with end-around carry
    always_comb begin
        add_a = r_base;
        add_b = '0;
        case (r_state)
            ipv4fhg_pkg::S_BASE: begin
                case (r_step)
                    3'd0:    add_b = ipv4fhg_pkg::VerIhlTos;
                    3'd1:    add_b = r_id;
                    3'd2:    add_b = {r_ttl, r_proto};
                    3'd3:    add_b = r_local_ip[31:16];
                    3'd4:    add_b = r_local_ip[15:0];
                    3'd5:    add_b = r_dst[31:16];
                    default: add_b = r_dst[15:0];
                endcase
            end
            ipv4fhg_pkg::S_TLEN: add_b = {{(WordW - ipv4fhg_pkg::TlenW){1'b0}}, tlen};
            ipv4fhg_pkg::S_FO: begin
                add_a = r_acc;
                add_b = flags_off;
            end
            default: add_b = '0;
        endcase
        add_raw = {1'b0, add_a} + {1'b0, add_b};
        add_sum = add_raw[WordW-1:0] + {{(WordW - 1){1'b0}}, add_raw[WordW]};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ipv4fhg_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_ident_cnt  <= '0;
            r_local_ip   <= '0;
            r_ttl        <= ipv4fhg_pkg::RstTtl;
            r_frag_units <= ipv4fhg_pkg::RstUnits;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) r_ident_cnt <= r_ident_cnt + 16'd1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ipv4fhg_pkg::RegLocalIp:   r_local_ip   <= i_cfg_data;
                    ipv4fhg_pkg::RegTtlValue:  r_ttl        <= i_cfg_data[7:0];
                    ipv4fhg_pkg::RegFragUnits: r_frag_units <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ipv4fhg_pkg::S_IDLE: begin
                r_rem   <= s_axis_tdata[15:0];
                r_dst   <= s_axis_tdata[47:16];
                r_proto <= s_axis_tdata[55:48];
                r_id    <= r_ident_cnt;
                r_units <= ipv4fhg_pkg::clamp_units(r_frag_units);
                r_offs  <= '0;
                r_step  <= '0;
                r_base  <= '0;
            end
            ipv4fhg_pkg::S_BASE: begin
                r_base <= add_sum;
                r_step <= r_step + 3'd1;
            end
            ipv4fhg_pkg::S_FRAG: begin
                // A remainder that fits in one fragment closes the datagram.
                if (r_rem > {{(ipv4fhg_pkg::LenW - ipv4fhg_pkg::SizeW){1'b0}}, frag_size}) begin
                    r_chunk <= frag_size;
                    r_fin   <= 1'b0;
                end else begin
                    r_chunk <= r_rem[ipv4fhg_pkg::TlenW-1:0];
                    r_fin   <= 1'b1;
                end
            end
            ipv4fhg_pkg::S_TLEN: r_acc <= add_sum;
            ipv4fhg_pkg::S_FO:   r_acc <= add_sum;
            ipv4fhg_pkg::S_EMIT: begin
                if (out_load) begin
                    r_out_data <= {~r_acc, r_offs, ~r_fin, r_id, tlen};
                    r_out_last <= r_fin;
                    r_rem      <= r_rem - {{(ipv4fhg_pkg::LenW - ipv4fhg_pkg::TlenW){1'b0}},
                                           r_chunk};
                    r_offs     <= r_offs + {{(ipv4fhg_pkg::OffW - ipv4fhg_pkg::UnitsW){1'b0}},
                                            r_units};
                end
            end
            default: ;
        endcase
    end

    // The final header of a datagram never claims more fragments.
    `IFHG_ASSERT(a_last_no_more, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[27])
    // Total length stays between a bare header and a 1500-byte packet.
    `IFHG_NEVER(a_tlen_range, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[10:0] > 11'd1500 || m_axis_tdata[10:0] < 11'd20))
    // Identification advances by exactly one per accepted descriptor.
    `IFHG_ASSERT(a_ident_step, i_clk, i_rst_n, in_fire |=> r_ident_cnt == $past(r_ident_cnt) + 16'd1)
    // A non-final fragment is always a full one.
    `IFHG_ASSERT(a_full_frag, i_clk, i_rst_n, out_load && !r_fin |-> r_chunk == frag_size)

endmodule

// ----- bench/ipv4_fragment_header_gen_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header checker
// Watches the descriptor, header and register channels of the fragment
// header generator. It predicts every fragment header from the accepted
// descriptors and compares the headers that leave the block, in order.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_checker
    import ipv4fhg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_desc_valid,
    input  logic               i_desc_ready,
    input  logic [55:0]        i_desc_data,
    input  logic               i_hdr_valid,
    input  logic               i_hdr_ready,
    input  logic [63:0]        i_hdr_data,
    input  logic               i_hdr_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_outstanding
);

    localparam logic [WordW-1:0] MoreFragsBit = 16'h2000;
    localparam int               MaxFrags     = 64;
    localparam int               MaxReports   = 40;

    typedef struct packed {
        logic [TlenW-1:0] total_len;
        logic [WordW-1:0] ident;
        logic             more_frags;
        logic [OffW-1:0]  frag_offset;
        logic [WordW-1:0] hdr_checksum;
        logic             last;
    } t_frag_hdr;

    t_frag_hdr         pending_hdrs[$];
    logic [AddrW-1:0]  src_ip;
    logic [7:0]        ttl;
    logic [UnitsW-1:0] units_reg;
    logic [WordW-1:0]  ident_ctr;
    int                err_count = 0;
    int                queued    = 0;

    assign o_errors      = err_count;
    assign o_outstanding = queued;

    // One step of the end-around-carry sum used by the IPv4 header checksum.
    function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] acc,
                                                  input logic [WordW-1:0] word);
        logic [WordW:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MaxReports)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
        end
    endfunction

    // Cut one datagram into fragments and queue the header of each.
    task automatic queue_fragments(input logic [LenW-1:0] len, input logic [AddrW-1:0] dst,
                                   input logic [ProtoW-1:0] proto);
        int unsigned      units;
        int unsigned      size;
        int unsigned      done;
        int unsigned      offs;
        int unsigned      chunk;
        int unsigned      n;
        bit               fin;
        logic [TlenW-1:0] tlen;
        logic [WordW-1:0] flags_off;
        logic [WordW-1:0] sum;
        t_frag_hdr        h;
        units = 32'(units_reg);
        if (units < 32'(MinUnits)) units = 32'(MinUnits);
        if (units > 32'(MaxUnits)) units = 32'(MaxUnits);
        size = units * 8;
        done = 0;
        offs = 0;
        n    = 0;
        fin  = 1'b0;
        while (!fin && n < MaxFrags) begin
            if (32'(len) - done > size) begin
                chunk = size;
            end else begin
                chunk = 32'(len) - done;
                fin   = 1'b1;
            end
            tlen      = HdrBytes + TlenW'(chunk);
            flags_off = (fin ? 16'h0000 : MoreFragsBit) | WordW'(OffW'(offs));
            sum = ones_add(16'h0000, VerIhlTos);
            sum = ones_add(sum, WordW'(tlen));
            sum = ones_add(sum, ident_ctr);
            sum = ones_add(sum, flags_off);
            sum = ones_add(sum, {ttl, proto});
            sum = ones_add(sum, src_ip[31:16]);
            sum = ones_add(sum, src_ip[15:0]);
            sum = ones_add(sum, dst[31:16]);
            sum = ones_add(sum, dst[15:0]);
            h.total_len    = tlen;
            h.ident        = ident_ctr;
            h.more_frags   = !fin;
            h.frag_offset  = OffW'(offs);
            h.hdr_checksum = ~sum;
            h.last         = fin;
            pending_hdrs.push_back(h);
            done += chunk;
            offs += units;
            n++;
        end
        ident_ctr = ident_ctr + 16'd1;
    endtask

    task automatic check_header();
        t_frag_hdr want;
        if (pending_hdrs.size() == 0) begin
            err_count++;
            if (err_count <= MaxReports)
                $display("%0t: header with no datagram pending, expected none, got 0x%0h",
                         $time, i_hdr_data);
        end else begin
            want = pending_hdrs.pop_front();
            compare_field("total_len",     32'(want.total_len),    32'(i_hdr_data[10:0]));
            compare_field("ident",         32'(want.ident),        32'(i_hdr_data[26:11]));
            compare_field("more_frags",    32'(want.more_frags),   32'(i_hdr_data[27]));
            compare_field("frag_offset",   32'(want.frag_offset),  32'(i_hdr_data[40:28]));
            compare_field("hdr_checksum",  32'(want.hdr_checksum), 32'(i_hdr_data[56:41]));
            compare_field("tdata padding", 32'd0,                  32'(i_hdr_data[63:57]));
            compare_field("tlast",         32'(want.last),         32'(i_hdr_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_hdrs.delete();
            src_ip    = '0;
            ttl       = RstTtl;
            units_reg = RstUnits;
            ident_ctr = '0;
        end else begin
            // Headers leave before the new datagram is queued behind them.
            if (i_hdr_valid && i_hdr_ready)
                check_header();
            if (i_desc_valid && i_desc_ready)
                queue_fragments(i_desc_data[15:0], i_desc_data[47:16], i_desc_data[55:48]);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    RegLocalIp:   src_ip    = i_cfg_data;
                    RegTtlValue:  ttl       = i_cfg_data[7:0];
                    RegFragUnits: units_reg = i_cfg_data[UnitsW-1:0];
                    default: ;
                endcase
            end
        end
        queued = pending_hdrs.size();
    end

endmodule

// ----- bench/tb_ipv4_fragment_header_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Drives datagram descriptors and register writes into the generator under
// random idling on both streams; a checker beside the block predicts and
// compares every fragment header. The top gives the verdict.
// ----------------------------------------------------------------------------
module tb_ipv4_fragment_header_gen;
    import ipv4fhg_pkg::*;

    // Index just past the register list; writes to it must be ignored.
    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [55:0]        s_axis_tdata;   // payload_len, dst_ip, proto_num from bit 0 up
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [63:0]        m_axis_tdata;   // total_len, ident, more_frags, frag_offset, checksum
    logic               m_axis_tlast;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0]        i_cfg_data;

    int                 mismatches;
    int                 headers_due;

    // Shared between the stimulus and the header receiver. When quiet is set
    // neither side idles; a nonzero hold_cycles asks the receiver for one
    // long stall so that the block backs up into its descriptor input.
    bit                 quiet       = 1'b0;
    int unsigned        hold_cycles = 0;
    logic [UnitsW-1:0]  units_now   = RstUnits;

    ipv4_fragment_header_gen dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ipv4_fragment_header_checker u_hdr_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc_valid  (s_axis_tvalid),
        .i_desc_ready  (s_axis_tready),
        .i_desc_data   (s_axis_tdata),
        .i_hdr_valid   (m_axis_tvalid),
        .i_hdr_ready   (m_axis_tready),
        .i_hdr_data    (m_axis_tdata),
        .i_hdr_last    (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_outstanding (headers_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run, in which every datagram
    // yields 64 fragments and every header waits out the longest stall.
    initial begin
        #20_000_000;
        $display("ipv4_fragment_header_gen regression: fail");
        $finish;
    end

    // Header receiver. Ready toggles in short random stalls, mixed with calm
    // stretches where it stays high, and once in a long hold when asked.
    initial begin
        int unsigned n;
        forever begin
            if (hold_cycles != 0) begin
                n             = hold_cycles;
                hold_cycles   = 0;
                m_axis_tready = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) < 2) begin
                n             = $urandom_range(1, 9);
                m_axis_tready = 1'b0;
            end else begin
                n             = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : 1;
                m_axis_tready = 1'b1;
            end
            repeat (n) @(negedge i_clk);
        end
    end

    // Offer one descriptor and hold it until the block takes the request.
    // Valid stays high on return so back-to-back requests need no gap.
    task automatic send_desc(input logic [LenW-1:0] len, input logic [AddrW-1:0] dst,
                             input logic [ProtoW-1:0] proto);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 9) < 3) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {proto, dst, len};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        if (idx == RegFragUnits)
            units_now = data[UnitsW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop offering descriptors and wait until every header has left. The
    // extra cycles let the sequencer return to idle after its last header.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (headers_due != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Payload lengths: often short, some spanning many fragments, a few up
    // to the full 16-bit range, and some landing right on a fragment edge.
    function automatic logic [LenW-1:0] pick_len();
        int unsigned eff;
        int unsigned pick;
        eff = 32'(units_now);
        if (eff < 32'(MinUnits)) eff = 32'(MinUnits);
        if (eff > 32'(MaxUnits)) eff = 32'(MaxUnits);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return LenW'($urandom_range(0, 1500));
        else if (pick < 70)
            return LenW'($urandom_range(0, 12000));
        else if (pick < 85)
            return LenW'($urandom_range(0, 65535));
        else
            return LenW'($urandom_range(1, 8) * eff * 8 + $urandom_range(0, 2) - 1);
    endfunction

    function automatic logic [UnitsW-1:0] pick_units();
        case ($urandom_range(0, 9))
            0:       return MinUnits;
            1:       return MaxUnits;
            2:       return UnitsW'($urandom_range(0, 255));
            default: return UnitsW'($urandom_range(MinUnits, MaxUnits));
        endcase
    endfunction

    initial begin
        logic [31:0] junk;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = RegLocalIp;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: 1480-byte fragments, TTL 64, source 0. Covers the
        // empty payload, a single byte, an exact single fragment, one byte
        // over, an exact multiple, and the top of the length range.
        send_desc(16'd0,     32'h0000_0000, 8'h00);
        send_desc(16'd1,     32'hFFFF_FFFF, 8'hFF);
        send_desc(16'd1480,  $urandom,      8'h11);
        send_desc(16'd1481,  $urandom,      8'h06);
        send_desc(16'd2960,  $urandom,      ProtoW'($urandom_range(0, 255)));
        send_desc(16'd65515, 32'hFFFF_FFFF, 8'hFF);
        send_desc(16'd65535, 32'h0000_0000, 8'h00);

        // Smallest fragments and all-ones header fields. The upper data
        // bits of the byte-wide registers carry noise that must be dropped.
        drain();
        junk = $urandom;
        write_reg(RegLocalIp,   32'hFFFF_FFFF);
        write_reg(RegTtlValue,  {junk[31:8], 8'hFF});
        write_reg(RegFragUnits, {junk[23:0], MinUnits});
        send_desc(16'd1024,  32'hFFFF_FFFF, 8'hFF);
        send_desc(16'd1025,  $urandom,      ProtoW'($urandom_range(0, 255)));
        send_desc(16'd2048,  $urandom,      ProtoW'($urandom_range(0, 255)));
        send_desc(16'd65535, 32'hFFFF_FFFF, 8'hFF);

        // Fragment size zero must act as the minimum, and a write past the
        // register list must change nothing.
        drain();
        write_reg(RegFragUnits, 32'd0);
        write_reg(RegSpare,     $urandom);
        write_reg(RegTtlValue,  32'd0);
        write_reg(RegLocalIp,   32'd0);
        send_desc(16'd1023,  32'h0000_0000, 8'h00);
        send_desc(16'd1025,  $urandom,      ProtoW'($urandom_range(0, 255)));
        send_desc(16'd65535, $urandom,      ProtoW'($urandom_range(0, 255)));

        // All-ones fragment size must act as the maximum.
        drain();
        write_reg(RegFragUnits, 32'hFFFF_FFFF);
        send_desc(16'd1481,  $urandom, ProtoW'($urandom_range(0, 255)));
        send_desc(16'd65535, $urandom, ProtoW'($urandom_range(0, 255)));

        // Just below and just above the supported fragment size range.
        drain();
        write_reg(RegFragUnits, 32'd127);
        send_desc(16'd1025, $urandom, ProtoW'($urandom_range(0, 255)));
        drain();
        write_reg(RegFragUnits, 32'd186);
        send_desc(16'd1481, $urandom, ProtoW'($urandom_range(0, 255)));

        // Random phases, each under a fresh register setting. The first one
        // opens with a long receiver hold so the block backs up into its
        // input; the last one runs with no idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            junk = $urandom;
            write_reg(RegLocalIp,   ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
            write_reg(RegTtlValue,  {junk[31:8], 8'($urandom_range(0, 255))});
            write_reg(RegFragUnits, {junk[23:0], pick_units()});
            if ($urandom_range(0, 1) == 0)
                write_reg(RegSpare, $urandom);
            if (phase == 0)
                hold_cycles = 400;
            if (phase == 3)
                quiet = 1'b1;
            for (int k = 0; k < 25; k++)
                send_desc(pick_len(), $urandom, ProtoW'($urandom_range(0, 255)));
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("ipv4_fragment_header_gen regression: pass");
        else
            $display("ipv4_fragment_header_gen regression: fail");
        $finish;
    end

endmodule
